// ===== sv/wmd_pkg.sv =====
`timescale 1ns / 1ps

package wmd_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned POSITION_W = 17;
  localparam int unsigned SEGLEN_W   = 16;

  // Output tdata: point_position, then point_value, zero padded to whole bytes.
  localparam int unsigned POINT_BITS = POSITION_W + SAMPLE_W;
  localparam int unsigned M_TDATA_W  = ((POINT_BITS + 7) / 8) * 8;
  localparam int unsigned S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

  // Defaults handed to the top level.
  localparam int unsigned WINDOW_SAMPLES_DEFAULT = 131072;
  localparam int unsigned QUEUE_DEPTH_DEFAULT    = 8;

  // Register reset value.
  localparam logic [SEGLEN_W-1:0] SEGMENT_LENGTH_RESET = SEGLEN_W'(1);

  // Most points one sample can produce: start point plus two extremes.
  localparam int unsigned MAX_POINTS = 3;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] value;
    logic [POSITION_W-1:0]      position;
  } point_t;

  // Points produced by one accepted sample, oldest in slot 0.
  typedef struct packed {
    logic [1:0]                  count;
    point_t [MAX_POINTS-1:0]     points;
  } push_t;

endpackage

// ===== sv/wmd_track.sv =====
`timescale 1ns / 1ps

module wmd_track #(
  parameter int unsigned WINDOW_SAMPLES = wmd_pkg::WINDOW_SAMPLES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic signed [wmd_pkg::SAMPLE_W-1:0] sample,
  input  logic                                window_end,
  input  logic [wmd_pkg::SEGLEN_W-1:0]        segment_length,
  output wmd_pkg::push_t                      push
);

  localparam int unsigned POS_W = (WINDOW_SAMPLES > 2) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int unsigned EXT_W = (POS_W > wmd_pkg::POSITION_W) ? POS_W
                                                                : wmd_pkg::POSITION_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_SAMPLES - 1);

  logic signed [wmd_pkg::SAMPLE_W-1:0] run_max, run_min;
  logic signed [wmd_pkg::SAMPLE_W-1:0] run_max_next, run_min_next;
  logic [POS_W-1:0]                    max_position, min_position;
  logic [POS_W-1:0]                    max_position_next, min_position_next;
  logic [POS_W-1:0]                    window_position;
  logic [wmd_pkg::SEGLEN_W-1:0]        segment_fill;

  logic [wmd_pkg::SEGLEN_W-1:0] seg_len;
  logic [wmd_pkg::SEGLEN_W:0]   fill_inc;
  logic                         last;
  logic                         closes;
  logic                         start;
  logic                         two_points;
  wmd_pkg::point_t              start_pt, max_pt, min_pt, first_pt, second_pt;

  // Positions leave the block as their low 17 bits.
  function automatic logic [wmd_pkg::POSITION_W-1:0] out_pos(input logic [POS_W-1:0] p);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(p);
    return ext[wmd_pkg::POSITION_W-1:0];
  endfunction

  // Running extremes; a later equal value keeps the earlier one.
  always_comb begin
    seg_len = (segment_length == '0) ? wmd_pkg::SEGLEN_W'(1) : segment_length;
    last    = window_end || (window_position == LAST_POS);
    start   = (window_position == '0);
    if (segment_fill == '0) begin
      run_max_next      = sample;
      run_min_next      = sample;
      max_position_next = window_position;
      min_position_next = window_position;
    end else begin
      run_max_next      = (sample > run_max) ? sample : run_max;
      max_position_next = (sample > run_max) ? window_position : max_position;
      run_min_next      = (sample < run_min) ? sample : run_min;
      min_position_next = (sample < run_min) ? window_position : min_position;
    end
    fill_inc = {1'b0, segment_fill} + 1'b1;
    closes   = last || (fill_inc >= {1'b0, seg_len});
  end

  // Order the segment's points in time; one point when both share an index.
  always_comb begin
    start_pt = '{done: 1'b0, value: sample, position: '0};
    max_pt   = '{done: 1'b0, value: run_max_next, position: out_pos(max_position_next)};
    min_pt   = '{done: 1'b0, value: run_min_next, position: out_pos(min_position_next)};
    two_points = (max_position_next != min_position_next);
    if (max_position_next < min_position_next) begin
      first_pt  = max_pt;
      second_pt = min_pt;
    end else begin
      first_pt  = min_pt;
      second_pt = max_pt;
    end
    first_pt.done  = last && !two_points;
    second_pt.done = last;

    push.points = '0;
    push.count  = '0;
    if (take) begin
      if (start) begin
        push.points[0] = start_pt;
        push.points[1] = first_pt;
        push.points[2] = second_pt;
      end else begin
        push.points[0] = first_pt;
        push.points[1] = second_pt;
      end
      push.count = 2'(start) + (closes ? (two_points ? 2'd2 : 2'd1) : 2'd0);
    end
  end

  // Segment and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_max         <= '0;
      run_min         <= '0;
      max_position    <= '0;
      min_position    <= '0;
      window_position <= '0;
      segment_fill    <= '0;
    end else if (take) begin
      run_max         <= run_max_next;
      run_min         <= run_min_next;
      max_position    <= max_position_next;
      min_position    <= min_position_next;
      window_position <= last ? '0 : window_position + 1'b1;
      segment_fill    <= closes ? '0 : fill_inc[wmd_pkg::SEGLEN_W-1:0];
    end
  end

endmodule

// ===== sv/wmd_queue.sv =====
`timescale 1ns / 1ps

// Point queue that takes up to three points per cycle and gives one when popped.
// DEPTH must be a power of two of at least four.
module wmd_queue #(
  parameter int unsigned DEPTH = wmd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wmd_pkg::push_t             push,
  input  logic                       pop,
  output wmd_pkg::point_t            head,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wmd_pkg::point_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] level_next;

  assign head      = entries[rd_ptr];
  assign not_empty = (level != '0);

  always_comb begin
    level_next = level + CNT_W'(push.count) - CNT_W'(pop && not_empty);
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    for (int i = 0; i < wmd_pkg::MAX_POINTS; i++) begin
      if (2'(i) < push.count) begin
        entries[wr_ptr + PTR_W'(i)] <= push.points[i];
      end
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level_next;
    end
  end

endmodule

// ===== sv/waveform_minmax_decimator_top.sv =====
`timescale 1ns / 1ps

// Min/max peak decimator for waveform display. Signed 16-bit samples arrive on
// the s_ stream, tlast marking the last sample of a window; the window is cut
// into segments of segment_length samples (0 acts as 1) and each segment yields
// its maximum and minimum with their window positions, in time order, or one
// point when both sit at the same index. The first sample of a window also
// yields a start point at position 0, and m_tlast flags a window's final point.
// A sample is taken in every cycle while the eight-entry point queue has room
// for three points, each sample's points being written into the queue as it is
// taken; one point leaves per cycle while m_tready is high, a sample yields zero
// to three points, and the output port sets the sustained rate. The user writes
// segment_length through cfg_ only while no transfer is pending (the block does not enforce it).
module waveform_minmax_decimator_top #(
  parameter int unsigned WINDOW_SAMPLES = wmd_pkg::WINDOW_SAMPLES_DEFAULT,
  parameter int unsigned QUEUE_DEPTH    = wmd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write: segment_length
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wmd_pkg::SEGLEN_W-1:0]  cfg_data,
  // Samples
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wmd_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] sample
  input  logic                          s_tlast,   // window_end
  // Points
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wmd_pkg::M_TDATA_W-1:0] m_tdata,   // [16:0] point_position, [32:17] point_value
  output logic                          m_tlast    // window_done
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [wmd_pkg::SEGLEN_W-1:0] segment_length;
  logic                         take;
  wmd_pkg::push_t               push;
  wmd_pkg::point_t              head;
  logic [CNT_W-1:0]             level;

  // Configuration register; no write is taken while in reset.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_length <= wmd_pkg::SEGMENT_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      segment_length <= cfg_data;
    end
  end

  // Accept a sample only while the queue can absorb its worst case.
  assign s_tready = !rst && (level <= CNT_W'(QUEUE_DEPTH - wmd_pkg::MAX_POINTS));
  assign take     = s_tvalid && s_tready;

  wmd_track #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .sample        (s_tdata[wmd_pkg::SAMPLE_W-1:0]),
    .window_end    (s_tlast),
    .segment_length(segment_length),
    .push          (push)
  );

  wmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (m_tready),
    .head     (head),
    .not_empty(m_tvalid),
    .level    (level)
  );

  // Output packing.
  assign m_tdata = wmd_pkg::M_TDATA_W'({head.value, head.position});
  assign m_tlast = head.done;

`ifndef NO_ASSERTIONS
  // The queue never holds more points than it has slots.
  assert property (@(posedge clk) disable iff (rst) level <= CNT_W'(QUEUE_DEPTH))
    else $error("point queue overflow");

  // A window's last sample always leaves at least one point behind it.
  assert property (@(posedge clk) disable iff (rst) (take && s_tlast) |=> m_tvalid)
    else $error("window end produced no point");

  // One sample adds at most three points to the queue.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (level <= $past(level) + CNT_W'(wmd_pkg::MAX_POINTS)))
    else $error("queue grew by more than three points");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WIN_SAMPLES  = wmd_pkg::WINDOW_SAMPLES_DEFAULT;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int          PREDICTED = -1;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic {ROW_SAMPLE, ROW_SEGLEN} row_kind_t;

  typedef struct {
    row_kind_t                                   kind;
    logic [15:0]                                 data;
    logic                                        last;
    int                                          count;
    wmd_pkg::point_t [wmd_pkg::MAX_POINTS-1:0]   pts;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [wmd_pkg::SEGLEN_W-1:0]   cfg_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [wmd_pkg::S_TDATA_W-1:0]  s_tdata;   // [15:0] sample
  logic                           s_tlast;   // window_end
  logic                           m_tvalid;
  logic                           m_tready;
  logic [wmd_pkg::M_TDATA_W-1:0]  m_tdata;   // [16:0] point_position, [32:17] point_value
  logic                           m_tlast;   // window_done

  // Predictor state, mirroring the block's registers.
  logic [wmd_pkg::SEGLEN_W-1:0]   seglen_cfg;
  logic signed [15:0]             peak_max;
  logic signed [15:0]             peak_min;
  logic [wmd_pkg::POSITION_W-1:0] peak_max_at;
  logic [wmd_pkg::POSITION_W-1:0] peak_min_at;
  int unsigned                    win_pos;
  int unsigned                    seg_fill;
  wmd_pkg::point_t                step_pts [wmd_pkg::MAX_POINTS];
  int                             step_n;

  wmd_pkg::point_t expected_points [$];
  stim_row_t       directed_rows [$];

  bit          idle_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned windows_done = 0;
  int unsigned points_seen = 0;
  int unsigned settings_written = 0;

  waveform_minmax_decimator_top #(
    .WINDOW_SAMPLES(WIN_SAMPLES),
    .QUEUE_DEPTH   (wmd_pkg::QUEUE_DEPTH_DEFAULT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d points still outstanding.",
               cycle_count, expected_points.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic wmd_pkg::point_t pt(input logic [wmd_pkg::POSITION_W-1:0] pos,
                                         input logic signed [15:0] val, input logic done);
    wmd_pkg::point_t p;
    p.position = pos;
    p.value    = val;
    p.done     = done;
    return p;
  endfunction

  task automatic note_point(input logic [wmd_pkg::POSITION_W-1:0] pos,
                            input logic signed [15:0] val);
    step_pts[step_n] = pt(pos, val, 1'b0);
    step_n++;
  endtask

  // Fold one sample into the open segment and work out the points it releases.
  task automatic decimate_sample(input logic signed [15:0] s, input logic win_end);
    int unsigned eff_len;
    int unsigned here;
    logic        closing_window;
    eff_len = (seglen_cfg == 0) ? 1 : seglen_cfg;
    here = win_pos;
    closing_window = win_end;
    step_n = 0;
    // A window that runs to the full capacity is closed by force.
    if (here + 1 >= WIN_SAMPLES) closing_window = 1'b1;
    if (here == 0) note_point('0, s);
    if (seg_fill == 0) begin
      peak_max = s;
      peak_min = s;
      peak_max_at = here[wmd_pkg::POSITION_W-1:0];
      peak_min_at = here[wmd_pkg::POSITION_W-1:0];
    end else begin
      // Equal values never displace the extreme already held.
      if (s > peak_max) begin
        peak_max = s;
        peak_max_at = here[wmd_pkg::POSITION_W-1:0];
      end
      if (s < peak_min) begin
        peak_min = s;
        peak_min_at = here[wmd_pkg::POSITION_W-1:0];
      end
    end
    seg_fill++;
    if (closing_window || seg_fill >= eff_len) begin
      if (peak_max_at < peak_min_at) begin
        note_point(peak_max_at, peak_max);
        note_point(peak_min_at, peak_min);
      end else if (peak_max_at > peak_min_at) begin
        note_point(peak_min_at, peak_min);
        note_point(peak_max_at, peak_max);
      end else begin
        note_point(peak_min_at, peak_min);
      end
      seg_fill = 0;
    end
    if (closing_window) begin
      step_pts[step_n-1].done = 1'b1;
      win_pos = 0;
      windows_done++;
    end else begin
      win_pos = here + 1;
    end
  endtask

  task automatic add_row(input row_kind_t kind, input logic [15:0] data, input logic last,
                         input int count, input wmd_pkg::point_t p0,
                         input wmd_pkg::point_t p1, input wmd_pkg::point_t p2);
    stim_row_t r;
    r.kind   = kind;
    r.data   = data;
    r.last   = last;
    r.count  = count;
    r.pts[0] = p0;
    r.pts[1] = p1;
    r.pts[2] = p2;
    directed_rows.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input wmd_pkg::point_t want,
                               input wmd_pkg::point_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display({"Mismatch (%s) at cycle %0d: expected pos %0d val %0d done %0b, ",
                "got pos %0d val %0d done %0b"},
               what, cycle_count, want.position, want.value, want.done,
               got.position, got.value, got.done);
  endtask

  // Output side: check every point transfer against the oldest expectation.
  always @(posedge clk) begin : point_check
    wmd_pkg::point_t got;
    wmd_pkg::point_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.position = m_tdata[wmd_pkg::POSITION_W-1:0];
      got.value    = m_tdata[wmd_pkg::POINT_BITS-1:wmd_pkg::POSITION_W];
      got.done     = m_tlast;
      points_seen++;
      if (expected_points.size() == 0) begin
        flag_mismatch("unexpected point", '0, got);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) flag_mismatch("field", want, got);
      end
    end
    m_tready <= idle_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
  end

  // Present one sample and hold it until the transfer; entered and left at a rising edge.
  task automatic send_sample(input logic [15:0] data, input logic last, input bit push_predicted);
    while (idle_on && ($urandom_range(0, 99) < 25)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
    decimate_sample(data, last);
    if (push_predicted)
      for (int k = 0; k < step_n; k++) expected_points.push_back(step_pts[k]);
  endtask

  // Drain all outstanding points, then give the block time to finish silent work.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seglen(input logic [wmd_pkg::SEGLEN_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seglen_cfg = value;
    settings_written++;
  endtask

  // Random samples weighted towards extremes and repeats, so ties occur often.
  function automatic logic [15:0] pick_sample(input logic [15:0] prev);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 16'h7FFF;
    if (roll < 20) return 16'h8000;
    if (roll < 40) return prev;
    if (roll < 50) return 16'($urandom_range(0, 7)) - 16'd4;
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    stim_row_t       r;
    logic [15:0]     prev;
    int unsigned     wlen;
    int unsigned     rand_items;
    int unsigned     windows_left;
    wmd_pkg::point_t none;

    none = '0;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    m_tready  <= 1'b0;

    seglen_cfg  = wmd_pkg::SEGMENT_LENGTH_RESET;
    peak_max    = '0;
    peak_min    = '0;
    peak_max_at = '0;
    peak_min_at = '0;
    win_pos     = 0;
    seg_fill    = 0;

    // Directed table. Rows with a count carry points read straight off the behaviour.
    // Reset length of one: every sample is its own segment.
    add_row(ROW_SAMPLE, 16'h7FFF, 1'b0, 2,
            pt(0, 16'sh7FFF, 1'b0), pt(0, 16'sh7FFF, 1'b0), none);
    add_row(ROW_SAMPLE, 16'h8000, 1'b1, 1, pt(1, 16'sh8000, 1'b1), none, none);
    // Single-sample window: start point plus one closing point, both at zero.
    add_row(ROW_SAMPLE, 16'd5, 1'b1, 2, pt(0, 16'sd5, 1'b0), pt(0, 16'sd5, 1'b1), none);
    // A length of zero behaves as one.
    add_row(ROW_SEGLEN, 16'd0, 1'b0, 0, none, none, none);
    add_row(ROW_SAMPLE, 16'hFFFF, 1'b0, 2,
            pt(0, -16'sd1, 1'b0), pt(0, -16'sd1, 1'b0), none);
    add_row(ROW_SAMPLE, 16'd0, 1'b1, 1, pt(1, 16'sd0, 1'b1), none, none);
    // Segments of three: ties, max-first, min-first and a short last segment.
    add_row(ROW_SEGLEN, 16'd3, 1'b0, 0, none, none, none);
    add_row(ROW_SAMPLE, 16'd10, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, 16'd10, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, -16'sd20, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, -16'sd20, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, 16'd30, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, 16'd30, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, 16'd1, 1'b1, PREDICTED, none, none, none);
    // Longest segment: only the window end closes it.
    add_row(ROW_SEGLEN, 16'hFFFF, 1'b0, 0, none, none, none);
    add_row(ROW_SAMPLE, 16'd100, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, -16'sd100, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, 16'h7FFF, 1'b0, PREDICTED, none, none, none);
    add_row(ROW_SAMPLE, 16'h8000, 1'b1, PREDICTED, none, none, none);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_SEGLEN) begin
        write_seglen(r.data);
      end else begin
        send_sample(r.data, r.last, r.count == PREDICTED);
        if (r.count != PREDICTED)
          for (int k = 0; k < r.count; k++) expected_points.push_back(r.pts[k]);
      end
    end

    // Random phases: a new segment length, then a few whole windows.
    rand_items = 0;
    prev = '0;
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: write_seglen(16'd0);
        1: write_seglen(16'd1);
        2: write_seglen(16'd2);
        3: write_seglen(16'($urandom_range(3, 9)));
        4: write_seglen(16'hFFFF);
        default: write_seglen(16'($urandom_range(1, 16)));
      endcase
      windows_left = $urandom_range(2, 5);
      while (windows_left > 0) begin
        wlen = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 24);
        for (int unsigned k = 0; k < wlen; k++) begin
          // A stretch in the middle runs with both sides always ready.
          idle_on = !(rand_items >= 150 && rand_items < 250);
          prev = pick_sample(prev);
          send_sample(prev, k == wlen - 1, 1'b1);
          rand_items++;
        end
        windows_left--;
      end
    end
    idle_on = 1'b1;

    // Drain, then report.
    settle();
    repeat (20) @(posedge clk);
    if (expected_points.size() != 0) begin
      $display("%0d expected points never arrived.", expected_points.size());
      mismatches += expected_points.size();
    end
    $display("Sent %0d samples in %0d windows over %0d segment-length settings.",
             samples_sent, windows_done, settings_written);
    $display("Checked %0d points, %0d mismatches.", points_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
